// ===== rtl/dorq_pkg.sv =====
// ---------------------------------------------------------------------------
// dorq_pkg
// Types and codes shared by the drop-oldest ring queue.
// ---------------------------------------------------------------------------
package dorq_pkg;

   localparam int ACTION_BITS = 2;
   localparam int WORD_BITS   = 64;
   localparam int AMOUNT_BITS = 7;

   localparam logic [ACTION_BITS-1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_FETCH   = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_REMOVE  = 2'd2;
   localparam logic [ACTION_BITS-1:0] ACT_CLEAR   = 2'd3;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [WORD_BITS-1:0]   record_word;
      logic [AMOUNT_BITS-1:0] batch_limit;
      logic [AMOUNT_BITS-1:0] remove_amount;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]   item_data;
      logic                   item_valid;
      logic                   last;
      logic [AMOUNT_BITS-1:0] occupancy;
      logic                   dropped_oldest;
      logic [AMOUNT_BITS-1:0] fetched_total;
   } rsp_type;

endpackage

// ===== rtl/drop_oldest_ring_queue.sv =====
// ---------------------------------------------------------------------------
// drop_oldest_ring_queue
// Ring-buffer queue of records that drops the oldest record on a full
// enqueue, with batch fetch, remove and clear.
//
//   channel   direction   transfer when           payload
//   req_      in          req_valid & !req_stall  dorq_pkg::req_type
//   rsp_      out         rsp_valid & !rsp_stall  dorq_pkg::rsp_type
//
// Enqueue, remove, clear and an empty fetch each give one result.
// A fetch of n records issues one record-store read per cycle while rsp_stall
// does not hold the read stage, starting the cycle after the request transfer;
// each record passes the store's registered read, then the output register.
// One item is in work at a time; the next is taken once its last result
// sits in the output register. rsp_stall holds the read stage and the store.
// Synchronous reset empties the queue; store contents are not cleared.
// ---------------------------------------------------------------------------
module drop_oldest_ring_queue #(
   parameter int QUEUE_DEPTH = 64,
   parameter int RECORD_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dorq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dorq_pkg::rsp_type rsp_payload
);

   import dorq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_FETCH = 1'b1;

   logic             state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic             p1_valid_ff, p1_valid_in;
   logic             p1_last_ff, p1_last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic                   out_free;
   logic                   req_fire;
   logic                   rd_en;
   logic                   wr_en;
   logic [RECORD_BITS-1:0] rd_data;
   logic [AMOUNT_BITS-1:0] count_ext;
   logic [AMOUNT_BITS-1:0] fetch_n;
   logic [AMOUNT_BITS-1:0] remove_n;
   logic [SUM_W-1:0]       head_sum;

   function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
      ring_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   dorq_ram #(
      .WIDTH (RECORD_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_payload.record_word[RECORD_BITS-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_fire  = req_valid && !req_stall;
   assign wr_en     = req_fire && (req_payload.action == ACT_ENQUEUE);
   assign rd_en     = (state_ff == ST_FETCH) && (left_ff != '0)
                      && (!p1_valid_ff || out_free);

   assign count_ext = AMOUNT_BITS'(count_ff);
   assign fetch_n   = (req_payload.batch_limit < count_ext) ?
                      req_payload.batch_limit : count_ext;
   assign remove_n  = (req_payload.remove_amount < count_ext) ?
                      req_payload.remove_amount : count_ext;
   assign head_sum  = SUM_W'(head_ff) + SUM_W'(remove_n);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      left_in      = left_ff;
      total_in     = total_ff;
      p1_valid_in  = p1_valid_ff;
      p1_last_in   = p1_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // read stage -> output register
      if (p1_valid_ff && out_free) begin
         p1_valid_in           = 1'b0;
         rsp_valid_in          = 1'b1;
         rsp_in.item_data      = WORD_BITS'(rd_data);
         rsp_in.item_valid     = 1'b1;
         rsp_in.last           = p1_last_ff;
         rsp_in.occupancy      = count_ext;
         rsp_in.dropped_oldest = 1'b0;
         rsp_in.fetched_total  = AMOUNT_BITS'(total_ff);
         if (p1_last_ff) begin
            state_in = ST_IDLE;
         end
      end

      if (rd_en) begin
         rd_idx_in   = ring_inc(rd_idx_ff);
         left_in     = left_ff - 1'b1;
         p1_valid_in = 1'b1;
         p1_last_in  = (left_ff == CNT_W'(1));
      end

      if (req_fire) begin
         rsp_in.item_data      = '0;
         rsp_in.item_valid     = 1'b0;
         rsp_in.last           = 1'b1;
         rsp_in.dropped_oldest = 1'b0;
         rsp_in.fetched_total  = '0;
         rsp_in.occupancy      = count_ext;
         rsp_valid_in          = 1'b1;
         case (req_payload.action)
            ACT_ENQUEUE: begin
               tail_in = ring_inc(tail_ff);
               if (count_ff == FULL_CNT) begin
                  head_in               = ring_inc(head_ff);
                  rsp_in.dropped_oldest = 1'b1;
               end else begin
                  count_in         = count_ff + 1'b1;
                  rsp_in.occupancy = AMOUNT_BITS'(count_ff + 1'b1);
               end
            end
            ACT_FETCH: begin
               if (fetch_n != '0) begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_FETCH;
                  rd_idx_in    = head_ff;
                  left_in      = CNT_W'(fetch_n);
                  total_in     = CNT_W'(fetch_n);
               end
            end
            ACT_REMOVE: begin
               head_in          = (head_sum >= DEPTH_S) ?
                                  IDX_W'(head_sum - DEPTH_S) : IDX_W'(head_sum);
               count_in         = count_ff - CNT_W'(remove_n);
               rsp_in.occupancy = count_ext - remove_n;
            end
            ACT_CLEAR: begin
               head_in          = '0;
               tail_in          = '0;
               count_in         = '0;
               rsp_in.occupancy = '0;
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         left_ff      <= '0;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      total_ff   <= total_in;
      p1_last_ff <= p1_last_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/dorq_ram.sv =====
// ---------------------------------------------------------------------------
// dorq_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// Read data holds while the read enable is low.
// ---------------------------------------------------------------------------
module dorq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench for drop_oldest_ring_queue. It runs a short table of queue
// operations, then random enqueue-heavy fill traffic and mixed traffic, with
// random gaps on both channels and one long receiver hold-off. Every result
// transfer is compared field by field with a ring-buffer predictor.
// ---------------------------------------------------------------------------
module tb;
   import dorq_pkg::*;

   localparam int RING_DEPTH = 64;
   localparam int LONG_HOLD  = 150;

   typedef struct {
      req_type          req;
      bit               typed;
      logic [AMOUNT_BITS-1:0] occ;
   } plan_step_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   logic [WORD_BITS-1:0]   ring_mem [RING_DEPTH];
   logic [5:0]             ring_head;
   logic [5:0]             ring_tail;
   logic [AMOUNT_BITS-1:0] ring_count;

   rsp_type       rsp_due [$];
   plan_step_type directed [$];
   int            mismatch_count = 0;
   bit            no_gaps = 1'b0;
   bit            hold_off = 1'b0;

   drop_oldest_ring_queue u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("drop_oldest_ring_queue: mismatch");
      $finish;
   end

   function automatic rsp_type make_rsp(logic [WORD_BITS-1:0] data, logic vld, logic lst,
                                        logic [AMOUNT_BITS-1:0] occ, logic drop,
                                        logic [AMOUNT_BITS-1:0] total);
      rsp_type r;
      r.item_data      = data;
      r.item_valid     = vld;
      r.last           = lst;
      r.occupancy      = occ;
      r.dropped_oldest = drop;
      r.fetched_total  = total;
      return r;
   endfunction

   // ring-buffer predictor: updates its own state and queues the due results
   function automatic void apply_action(req_type it);
      logic                   drop;
      logic [AMOUNT_BITS-1:0] n;
      logic [5:0]             idx;
      int                     k;
      case (it.action)
         ACT_ENQUEUE: begin
            drop = (ring_count == AMOUNT_BITS'(RING_DEPTH));
            if (drop) begin
               ring_head  = ring_head + 6'd1;
               ring_count = ring_count - 7'd1;
            end
            ring_mem[ring_tail] = it.record_word;
            ring_tail  = ring_tail + 6'd1;
            ring_count = ring_count + 7'd1;
            rsp_due.push_back(make_rsp('0, 1'b0, 1'b1, ring_count, drop, '0));
         end
         ACT_FETCH: begin
            n = (it.batch_limit < ring_count) ? it.batch_limit : ring_count;
            idx = ring_head;
            if (n == 0) begin
               rsp_due.push_back(make_rsp('0, 1'b0, 1'b1, ring_count, 1'b0, '0));
            end else begin
               for (k = 0; k < n; k++) begin
                  rsp_due.push_back(make_rsp(ring_mem[idx], 1'b1, k == n - 1, ring_count,
                                             1'b0, n));
                  idx = idx + 6'd1;
               end
            end
         end
         ACT_REMOVE: begin
            n = (it.remove_amount < ring_count) ? it.remove_amount : ring_count;
            ring_head  = ring_head + n[5:0];
            ring_count = ring_count - n;
            rsp_due.push_back(make_rsp('0, 1'b0, 1'b1, ring_count, 1'b0, '0));
         end
         default: begin
            ring_head  = '0;
            ring_tail  = '0;
            ring_count = '0;
            rsp_due.push_back(make_rsp('0, 1'b0, 1'b1, ring_count, 1'b0, '0));
         end
      endcase
   endfunction

   function automatic plan_step_type row(logic [ACTION_BITS-1:0] act,
                                         logic [WORD_BITS-1:0] word,
                                         logic [AMOUNT_BITS-1:0] lim,
                                         logic [AMOUNT_BITS-1:0] amt,
                                         bit typed, logic [AMOUNT_BITS-1:0] occ);
      plan_step_type s;
      s.req.action        = act;
      s.req.record_word   = word;
      s.req.batch_limit   = lim;
      s.req.remove_amount = amt;
      s.typed             = typed;
      s.occ               = occ;
      return s;
   endfunction

   function automatic logic [AMOUNT_BITS-1:0] random_amount(int common_max);
      if ($urandom_range(0, 9) != 0)
         return AMOUNT_BITS'($urandom_range(0, common_max));
      if ($urandom_range(0, 1) != 0)
         return AMOUNT_BITS'(RING_DEPTH);
      return AMOUNT_BITS'($urandom_range(0, RING_DEPTH));
   endfunction

   function automatic req_type random_item(bit filling);
      req_type it;
      int      pick;
      it.record_word   = {$urandom, $urandom};
      it.batch_limit   = random_amount(6);
      it.remove_amount = random_amount(4);
      pick = $urandom_range(0, 99);
      if (filling)
         it.action = ACT_ENQUEUE;
      else if (pick < 40)
         it.action = ACT_ENQUEUE;
      else if (pick < 66)
         it.action = ACT_FETCH;
      else if (pick < 92)
         it.action = ACT_REMOVE;
      else
         it.action = ACT_CLEAR;
      return it;
   endfunction

   function automatic void field_diff(string name, logic [WORD_BITS-1:0] want,
                                      logic [WORD_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic send_item(req_type it, bit typed, logic [AMOUNT_BITS-1:0] occ);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (req_stall);
      apply_action(it);
      if (typed) begin
         void'(rsp_due.pop_back());
         rsp_due.push_back(make_rsp('0, 1'b0, 1'b1, occ, 1'b0, '0));
      end
      @(negedge clock);
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_due.size() == 0) begin
            $display("%0t: transfer with none due, expected nothing, got %p",
                     $time, rsp_payload);
            mismatch_count++;
         end else begin
            want = rsp_due.pop_front();
            field_diff("item_data", want.item_data, rsp_payload.item_data);
            field_diff("item_valid", WORD_BITS'(want.item_valid),
                       WORD_BITS'(rsp_payload.item_valid));
            field_diff("last", WORD_BITS'(want.last), WORD_BITS'(rsp_payload.last));
            field_diff("occupancy", WORD_BITS'(want.occupancy),
                       WORD_BITS'(rsp_payload.occupancy));
            field_diff("dropped_oldest", WORD_BITS'(want.dropped_oldest),
                       WORD_BITS'(rsp_payload.dropped_oldest));
            field_diff("fetched_total", WORD_BITS'(want.fetched_total),
                       WORD_BITS'(rsp_payload.fetched_total));
         end
      end
   end

   initial begin : receiver
      int wait_cycles;
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            hold_off    = 1'b0;
            wait_cycles = LONG_HOLD;
         end else begin
            wait_cycles = no_gaps ? 0 : $urandom_range(0, 9);
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin : sender
      int      i;
      req_type fill_it;
      ring_head  = '0;
      ring_tail  = '0;
      ring_count = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed.push_back(row(ACT_FETCH,   64'hFFFF_0000_FFFF_0000, 7'd64, 7'd3,  1, 7'd0));
      directed.push_back(row(ACT_REMOVE,  64'h0,                   7'd5,  7'd64, 1, 7'd0));
      directed.push_back(row(ACT_ENQUEUE, 64'h0,                   7'd64, 7'd64, 1, 7'd1));
      directed.push_back(row(ACT_ENQUEUE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0,  7'd0,  1, 7'd2));
      directed.push_back(row(ACT_ENQUEUE, 64'h0123_4567_89AB_CDEF, 7'd1,  7'd1,  1, 7'd3));
      directed.push_back(row(ACT_FETCH,   64'hFFFF_FFFF_FFFF_FFFF, 7'd0,  7'd64, 1, 7'd3));
      directed.push_back(row(ACT_FETCH,   64'h0,                   7'd2,  7'd0,  0, 7'd0));
      directed.push_back(row(ACT_FETCH,   64'h0,                   7'd64, 7'd0,  0, 7'd0));
      directed.push_back(row(ACT_REMOVE,  64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 7'd0,  1, 7'd3));
      directed.push_back(row(ACT_REMOVE,  64'h0,                   7'd0,  7'd1,  1, 7'd2));
      directed.push_back(row(ACT_FETCH,   64'h0,                   7'd64, 7'd64, 0, 7'd0));
      directed.push_back(row(ACT_REMOVE,  64'h0,                   7'd0,  7'd64, 1, 7'd0));
      directed.push_back(row(ACT_ENQUEUE, 64'hA5A5_A5A5_A5A5_A5A5, 7'd0,  7'd0,  1, 7'd1));
      directed.push_back(row(ACT_ENQUEUE, 64'h5A5A_5A5A_5A5A_5A5A, 7'd0,  7'd0,  1, 7'd2));
      directed.push_back(row(ACT_FETCH,   64'h0,                   7'd1,  7'd0,  0, 7'd0));
      directed.push_back(row(ACT_CLEAR,   64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 7'd64, 1, 7'd0));
      directed.push_back(row(ACT_FETCH,   64'h0,                   7'd64, 7'd0,  1, 7'd0));
      directed.push_back(row(ACT_ENQUEUE, 64'h8000_0000_0000_0001, 7'd0,  7'd0,  1, 7'd1));
      directed.push_back(row(ACT_FETCH,   64'h0,                   7'd64, 7'd0,  0, 7'd0));
      directed.push_back(row(ACT_REMOVE,  64'h0,                   7'd0,  7'd1,  1, 7'd0));

      foreach (directed[i])
         send_item(directed[i].req, directed[i].typed, directed[i].occ);

      // fill past the depth so the oldest records drop and the ring wraps
      for (i = 0; i < 72; i++) begin
         no_gaps = (i >= 24 && i < 40);
         fill_it = random_item(1'b1);
         if (i % 12 == 11)
            fill_it.action = ACT_FETCH;
         send_item(fill_it, 1'b0, '0);
      end
      no_gaps  = 1'b0;
      hold_off = 1'b1;
      for (i = 0; i < 18; i++)
         send_item(random_item(1'b0), 1'b0, '0);
      req_valid <= 1'b0;

      while (rsp_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("drop_oldest_ring_queue: match");
      else
         $display("drop_oldest_ring_queue: mismatch");
      $finish;
   end

endmodule
